@@ design/nbf_pkg.sv @@
// ----------------------------------------------------------------------------
// nbf_pkg
// Shared types, constants and helpers for the nine-byte frame sensor decoder.
// ----------------------------------------------------------------------------
package nbf_pkg;

  // Frame geometry: the window keeps all but the closing byte of a frame.
  localparam int FRAME_LEN = 9;
  localparam int WIN_DEPTH = FRAME_LEN - 1;

  // Framing bytes.
  localparam logic [7:0] SYNC_HEAD = 8'h01;
  localparam logic [7:0] SYNC_TAIL = 8'hAA;

  // Frame class and type bytes.
  localparam logic [7:0] CLS_SENSOR    = 8'h02;
  localparam logic [7:0] TYP_TOUCH     = 8'h13;
  localparam logic [7:0] TYP_PERSON    = 8'h14;
  localparam logic [7:0] CLS_CTRL      = 8'h22;
  localparam logic [7:0] TYP_RESET_A   = 8'h50;
  localparam logic [7:0] TYP_RESET_B   = 8'h51;
  localparam logic [7:0] TYP_WHEEL_STP = 8'h56;
  localparam logic [7:0] TYP_WHEEL_QRY = 8'h59;
  localparam logic [7:0] CLS_TRAY      = 8'h92;
  localparam logic [7:0] TYP_TRAY      = 8'h03;
  localparam logic [7:0] SUB_TRAY      = 8'h01;
  localparam logic [7:0] CLS_IR        = 8'h95;
  localparam logic [7:0] TYP_IR        = 8'h01;
  localparam logic [7:0] BYTE_ZERO     = 8'h00;

  // Number of infrared channels carried by an infrared frame.
  localparam int IR_CNT = 4;

  // Wheel frame marks.
  typedef enum logic [1:0] {
    WHEEL_NONE  = 2'd0,
    WHEEL_STOP  = 2'd1,
    WHEEL_QUERY = 2'd2
  } wheel_t;

  // Full frame, byte 0 is the oldest.
  typedef logic [7:0] frame_t [FRAME_LEN];

  // Infrared distance set.
  typedef logic [7:0] ir_set_t [IR_CNT];

  // Everything the decoder extracts from one frame.
  typedef struct packed {
    logic [3:0]  touch;
    logic        reset_req;
    wheel_t      wheel;
    logic        moving_upd;
    logic        moving_val;
    logic        dist_upd;
    logic [15:0] dist_a;
    logic [15:0] dist_b;
    logic        ir_upd;
  } dec_t;

  // Halve a byte, rounding up.
  function automatic logic [7:0] half_up(input logic [7:0] b);
    logic [8:0] sum;
    sum = {1'b0, b} + 9'd1;
    return sum[8:1];
  endfunction

endpackage

@@ design/nine_byte_frame_sensor_decoder.sv @@
// ----------------------------------------------------------------------------
// nine_byte_frame_sensor_decoder
// Finds nine-byte sensor frames in a received byte stream and decodes them.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_*: one received byte per item (in_rx_byte), taken when
//   in_valid is high and in_stall is low.
//   Result channel out_*: exactly one result item per input item, offered on
//   out_valid and taken when out_stall is low. frame_done marks the byte that
//   closed a frame (oldest byte 0x01, closing byte 0xAA); the event fields are
//   zero otherwise, and the held fields always show the current sensor state.
//   Configuration channel cfg_*: one write sets send_enable; always ready.
// Timing:
//   The result of an accepted byte is offered in the next cycle. One byte is
//   taken every cycle while the receiver keeps up; the single result register
//   is refilled in the same cycle it drains.
//   in_stall is raised only while a result waits and out_stall is high.
// Reset:
//   Window empty, held distances and motion flag zero, send_enable set,
//   no result pending.
// ----------------------------------------------------------------------------
module nine_byte_frame_sensor_decoder (
  input  logic        clk,
  input  logic        rst_n,
  // Byte input
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  // Configuration write
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_send_enable,
  // Results
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_frame_done,
  output logic [3:0]  out_touch_events,
  output logic        out_person_moving,
  output logic        out_send_reset,
  output logic [1:0]  out_wheel_frame,
  output logic [15:0] out_person_dist_a,
  output logic [15:0] out_person_dist_b,
  output logic [7:0]  out_ir_dist_0,
  output logic [7:0]  out_ir_dist_1,
  output logic [7:0]  out_ir_dist_2,
  output logic [7:0]  out_ir_dist_3
);
  import nbf_pkg::*;

  logic       accept;
  logic       frame_hit;
  logic [7:0] win_data  [WIN_DEPTH + 1];
  logic       win_valid [WIN_DEPTH + 1];
  frame_t     frame;
  dec_t       dec;
  ir_set_t    ir_val;

  logic        send_enable_r;
  logic        out_valid_r,  out_valid_nxt;
  logic        done_r,       done_nxt;
  logic [3:0]  touch_r,      touch_nxt;
  logic        reset_req_r,  reset_req_nxt;
  wheel_t      wheel_r,      wheel_nxt;
  logic        moving_r,     moving_nxt;
  logic [15:0] dist_a_r,     dist_a_nxt;
  logic [15:0] dist_b_r,     dist_b_nxt;
  ir_set_t     ir_r,         ir_nxt;

  // Handshake: take a byte whenever the result register is free or draining.
  assign in_stall  = out_valid_r && out_stall;
  assign accept    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  // Byte window: a chain of cells, newest byte entering at cell 0.
  assign win_data[0]  = in_rx_byte;
  assign win_valid[0] = 1'b1;

  for (genvar g = 0; g < WIN_DEPTH; g++) begin : g_win
    nbf_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .shift_en (accept),
      .clear    (accept && frame_hit),
      .d_in     (win_data[g]),
      .v_in     (win_valid[g]),
      .d_out    (win_data[g + 1]),
      .v_out    (win_valid[g + 1])
    );
  end

  // Frame byte k sits in the cell k places from the oldest end.
  always_comb begin
    for (int k = 0; k < FRAME_LEN; k++) begin
      frame[k] = win_data[WIN_DEPTH - k];
    end
  end

  assign frame_hit = win_valid[WIN_DEPTH] && (win_data[WIN_DEPTH] == SYNC_HEAD) &&
                     (in_rx_byte == SYNC_TAIL);

  nbf_decode u_decode (
    .frame       (frame),
    .send_enable (send_enable_r),
    .dec         (dec),
    .ir_val      (ir_val)
  );

  // Next result and held sensor state.
  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    done_nxt      = done_r;
    touch_nxt     = touch_r;
    reset_req_nxt = reset_req_r;
    wheel_nxt     = wheel_r;
    moving_nxt    = moving_r;
    dist_a_nxt    = dist_a_r;
    dist_b_nxt    = dist_b_r;
    ir_nxt        = ir_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
      done_nxt      = frame_hit;
      touch_nxt     = '0;
      reset_req_nxt = 1'b0;
      wheel_nxt     = WHEEL_NONE;
      if (frame_hit) begin
        touch_nxt     = dec.touch;
        reset_req_nxt = dec.reset_req;
        wheel_nxt     = dec.wheel;
        if (dec.moving_upd) begin
          moving_nxt = dec.moving_val;
        end
        if (dec.dist_upd) begin
          dist_a_nxt = dec.dist_a;
          dist_b_nxt = dec.dist_b;
        end
        if (dec.ir_upd) begin
          ir_nxt = ir_val;
        end
      end
    end
  end

  // Control and held state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      send_enable_r <= 1'b1;
      out_valid_r   <= 1'b0;
      moving_r      <= 1'b0;
      dist_a_r      <= '0;
      dist_b_r      <= '0;
      for (int i = 0; i < IR_CNT; i++) begin
        ir_r[i] <= '0;
      end
    end else begin
      if (cfg_valid && cfg_ready) begin
        send_enable_r <= cfg_send_enable;
      end
      out_valid_r <= out_valid_nxt;
      moving_r    <= moving_nxt;
      dist_a_r    <= dist_a_nxt;
      dist_b_r    <= dist_b_nxt;
      ir_r        <= ir_nxt;
    end
  end

  // Per-item event payload.
  always_ff @(posedge clk) begin
    done_r      <= done_nxt;
    touch_r     <= touch_nxt;
    reset_req_r <= reset_req_nxt;
    wheel_r     <= wheel_nxt;
  end

  // Held state only changes when the result register is refilled, so it
  // drives the held output fields directly.
  assign out_valid         = out_valid_r;
  assign out_frame_done    = done_r;
  assign out_touch_events  = touch_r;
  assign out_person_moving = moving_r;
  assign out_send_reset    = reset_req_r;
  assign out_wheel_frame   = wheel_r;
  assign out_person_dist_a = dist_a_r;
  assign out_person_dist_b = dist_b_r;
  assign out_ir_dist_0     = ir_r[0];
  assign out_ir_dist_1     = ir_r[1];
  assign out_ir_dist_2     = ir_r[2];
  assign out_ir_dist_3     = ir_r[3];

  // A closed frame empties the window.
  a_frame_clears: assert property (@(posedge clk) disable iff (!rst_n)
    accept && frame_hit |=> !win_valid[WIN_DEPTH])
    else $error("window not cleared after a frame");

  // Events appear only on the byte that closes a frame.
  a_events_on_frame: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_frame_done |->
      out_touch_events == 4'd0 && !out_send_reset && out_wheel_frame == WHEEL_NONE)
    else $error("event reported without a frame");

  // A reset request needs the enable register set when the frame closed.
  a_reset_gated: assert property (@(posedge clk) disable iff (!rst_n)
    accept && frame_hit && !send_enable_r |=> !out_send_reset)
    else $error("reset request issued while disabled");

  // Held state is steady while a result is stalled.
  a_hold_steady: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(dist_a_r) && $stable(moving_r))
    else $error("held state changed under a stalled result");

endmodule

@@ design/nbf_cell.sv @@
// ----------------------------------------------------------------------------
// nbf_cell
// One stage of the byte window: holds a byte and its valid flag and hands
// both to the next stage when a new item is shifted in.
// ----------------------------------------------------------------------------
module nbf_cell (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       shift_en,
  input  logic       clear,
  input  logic [7:0] d_in,
  input  logic       v_in,
  output logic [7:0] d_out,
  output logic       v_out
);

  logic [7:0] data_r;
  logic       valid_r;
  logic [7:0] data_nxt;
  logic       valid_nxt;

  // A frame clears the valid flag; otherwise the neighbor's byte moves in.
  always_comb begin
    data_nxt  = data_r;
    valid_nxt = valid_r;
    if (clear) begin
      valid_nxt = 1'b0;
    end else if (shift_en) begin
      data_nxt  = d_in;
      valid_nxt = v_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // The byte itself needs no reset: it is only read while valid.
  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign d_out = data_r;
  assign v_out = valid_r;

endmodule

@@ design/nbf_decode.sv @@
// ----------------------------------------------------------------------------
// nbf_decode
// Classifies a complete frame by its class and type bytes and pulls out the
// touch, motion, distance, reset-request, wheel and infrared information.
// ----------------------------------------------------------------------------
module nbf_decode (
  input  nbf_pkg::frame_t  frame,
  input  logic             send_enable,
  output nbf_pkg::dec_t    dec,
  output nbf_pkg::ir_set_t ir_val
);
  import nbf_pkg::*;

  logic is_sensor;
  logic is_ctrl;

  assign is_sensor = (frame[1] == CLS_SENSOR);
  assign is_ctrl   = (frame[1] == CLS_CTRL);

  // Field extraction for each frame type.
  always_comb begin
    dec = '0;
    dec.wheel = WHEEL_NONE;

    // Touch and motion: active-low bits in byte 3.
    if (is_sensor && frame[2] == TYP_TOUCH) begin
      dec.touch[2:0] = ~frame[3][2:0];
      dec.moving_upd = 1'b1;
      dec.moving_val = ~frame[3][3];
    end

    // Two big-endian person distances.
    if (is_sensor && frame[2] == TYP_PERSON) begin
      dec.dist_upd = 1'b1;
      dec.dist_a   = {frame[3], frame[4]};
      dec.dist_b   = {frame[5], frame[6]};
    end

    // Reset command request, gated by the enable register.
    if (is_ctrl && (frame[2] == TYP_RESET_A || frame[2] == TYP_RESET_B) &&
        frame[3] == BYTE_ZERO && send_enable) begin
      dec.reset_req = 1'b1;
    end

    // Wheel frame marks.
    if (is_ctrl && frame[2] == TYP_WHEEL_STP) begin
      dec.wheel = WHEEL_STOP;
    end
    if (is_ctrl && frame[2] == TYP_WHEEL_QRY) begin
      dec.wheel = WHEEL_QUERY;
    end

    // Tray touch.
    if (frame[1] == CLS_TRAY && frame[2] == TYP_TRAY && frame[3] == SUB_TRAY) begin
      dec.touch[3] = 1'b1;
    end

    // Infrared distances.
    if (frame[1] == CLS_IR && frame[2] == TYP_IR) begin
      dec.ir_upd = 1'b1;
    end
  end

  // Rounded halves of the four infrared bytes.
  always_comb begin
    for (int i = 0; i < IR_CNT; i++) begin
      ir_val[i] = half_up(frame[3 + i]);
    end
  end

endmodule
